// ===== design/hwr_pkg.sv =====
// ----------------------------------------------------------------------------
// hwr_pkg
// shared types and constants for the hue wheel to normalized rgb block
// ----------------------------------------------------------------------------
package hwr_pkg;

   localparam logic [8:0]  WheelDeg        = 9'd360;
   localparam logic [7:0]  ChannelFull     = 8'hFF;
   localparam logic [7:0]  BrightnessReset = 8'h40;
   localparam logic [8:0]  Deg60           = 9'd60;
   localparam logic [8:0]  Deg120          = 9'd120;
   localparam logic [8:0]  Deg180          = 9'd180;
   localparam logic [8:0]  Deg240          = 9'd240;
   localparam logic [8:0]  Deg300          = 9'd300;

   // ceil(2^24 / 360), exact quotient for every 16-bit hue
   localparam logic [15:0] ModRecip        = 16'd46604;
   localparam int          ModShift        = 24;

   localparam int          Lanes           = 3;
   localparam int          QuoBits         = 8;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] sum;
   } chan_type;

   typedef struct packed {
      logic [Lanes-1:0][15:0]        rem;
      logic [Lanes-1:0][QuoBits-1:0] quo;
      logic [8:0]                    sum;
   } div_type;

   // offset * 255 / 60 == offset * 17 / 4
   function automatic logic [7:0] ramp_up(input logic [5:0] offset);
      logic [10:0] prod;
      prod = {5'b0, offset} * 11'd17;
      return prod[9:2];
   endfunction

endpackage

// ===== design/hwr_req_if.sv =====
// ----------------------------------------------------------------------------
// hwr_req_if
// request channel: one hue per item
// ----------------------------------------------------------------------------
interface hwr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] hue;

   modport source (output valid, output hue, input ready);
   modport sink   (input valid, input hue, output ready);
endinterface

// ===== design/hwr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hwr_rsp_if
// response channel: one rgb triple per item
// ----------------------------------------------------------------------------
interface hwr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/hwr_wheel.sv =====
// ----------------------------------------------------------------------------
// hwr_wheel
// three stage pipe: hue mod 360, then per channel ramps and their sum
// ----------------------------------------------------------------------------
module hwr_wheel (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [15:0]       in_hue,
   output logic              out_valid,
   input  logic              out_ready,
   output hwr_pkg::chan_type out_chan
);
   import hwr_pkg::*;

   logic [2:0]  v_ff;
   logic [3:0]  adv;

   logic [31:0] mod_prod;
   logic [7:0]  quo_in, quo_ff;
   logic [15:0] hue_ff;
   logic [16:0] quo_times;
   logic [15:0] diff;
   logic [8:0]  h_in, h_ff;
   logic [8:0]  off_r, off_g, off_b;
   chan_type    chan_in, chan_ff;

   always_comb begin
      adv[3] = out_ready;
      for (int k = 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   // stage 1: quotient by reciprocal multiply
   assign mod_prod = in_hue * ModRecip;
   assign quo_in   = mod_prod[ModShift+7:ModShift];

   // stage 2: remainder
   assign quo_times = {9'b0, quo_ff} * {8'b0, WheelDeg};
   assign diff      = hue_ff - quo_times[15:0];
   assign h_in      = diff[8:0];

   // stage 3: ramps
   always_comb begin
      off_r   = '0;
      off_g   = '0;
      off_b   = '0;
      chan_in = '0;

      if (h_ff >= Deg300 || h_ff <= Deg60) begin
         chan_in.red = ChannelFull;
      end else if (h_ff < Deg120) begin
         off_r       = Deg120 - h_ff;
         chan_in.red = ramp_up(off_r[5:0]);
      end else if (h_ff <= Deg240) begin
         chan_in.red = '0;
      end else begin
         off_r       = h_ff - Deg240;
         chan_in.red = ramp_up(off_r[5:0]);
      end

      if (h_ff == '0 || h_ff >= Deg240) begin
         chan_in.green = '0;
      end else if (h_ff < Deg60) begin
         off_g         = h_ff;
         chan_in.green = ramp_up(off_g[5:0]);
      end else if (h_ff <= Deg180) begin
         chan_in.green = ChannelFull;
      end else begin
         off_g         = Deg240 - h_ff;
         chan_in.green = ramp_up(off_g[5:0]);
      end

      if (h_ff <= Deg120) begin
         chan_in.blue = '0;
      end else if (h_ff < Deg180) begin
         off_b        = h_ff - Deg120;
         chan_in.blue = ramp_up(off_b[5:0]);
      end else if (h_ff <= Deg300) begin
         chan_in.blue = ChannelFull;
      end else begin
         off_b        = WheelDeg - h_ff;
         chan_in.blue = ramp_up(off_b[5:0]);
      end

      chan_in.sum = {1'b0, chan_in.red} + {1'b0, chan_in.green} + {1'b0, chan_in.blue};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         quo_ff <= quo_in;
         hue_ff <= in_hue;
      end
      if (adv[1]) h_ff    <= h_in;
      if (adv[2]) chan_ff <= chan_in;
   end

   assign out_valid = v_ff[2];
   assign out_chan  = chan_ff;

endmodule

// ===== design/hwr_norm.sv =====
// ----------------------------------------------------------------------------
// hwr_norm
// scale each channel by brightness, then divide by the channel sum,
// one quotient bit per stage for all three lanes
// ----------------------------------------------------------------------------
module hwr_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        brightness,
   input  logic              in_valid,
   output logic              in_ready,
   input  hwr_pkg::chan_type in_chan,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_red,
   output logic [7:0]        out_green,
   output logic [7:0]        out_blue
);
   import hwr_pkg::*;

   localparam int Stages = QuoBits + 1;

   logic [Stages-1:0]        v_ff;
   logic [Stages:0]          adv;
   div_type                  st_in [Stages];
   div_type                  st_ff [Stages];
   logic [Lanes-1:0][7:0]    ch;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < Stages; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // stage 0: numerators
   assign ch = {in_chan.blue, in_chan.green, in_chan.red};

   always_comb begin
      st_in[0]     = '0;
      st_in[0].sum = in_chan.sum;
      for (int l = 0; l < Lanes; l++) begin
         st_in[0].rem[l] = {8'b0, ch[l]} * {8'b0, brightness};
      end
   end

   // stages 1..8: restoring division, msb first
   for (genvar k = 1; k < Stages; k++) begin : g_step
      localparam int Bit = QuoBits - k;
      logic [15:0] dsh;
      logic [Lanes-1:0][16:0] diff;

      assign dsh = {7'b0, st_ff[k-1].sum} << Bit;

      always_comb begin
         st_in[k] = st_ff[k-1];
         for (int l = 0; l < Lanes; l++) begin
            diff[l] = {1'b0, st_ff[k-1].rem[l]} - {1'b0, dsh};
            if (!diff[l][16]) begin
               st_in[k].rem[l]      = diff[l][15:0];
               st_in[k].quo[l][Bit] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Stages; k++) begin
         if (adv[k]) st_ff[k] <= st_in[k];
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_red   = st_ff[Stages-1].quo[0];
   assign out_green = st_ff[Stages-1].quo[1];
   assign out_blue  = st_ff[Stages-1].quo[2];

endmodule

// ===== design/hue_wheel_to_rgb_normalized.sv =====
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb_normalized
// hue in degrees to an rgb triple whose channels share a set brightness
// ----------------------------------------------------------------------------
// req carries one 16-bit hue per item; any value is taken and reduced mod 360.
// rsp returns red, green and blue, each channel * brightness / channel sum,
// so the three bytes together never exceed brightness.
// csr_we / csr_wdata write the 8-bit brightness register, reset value 0x40;
// write it only while no item is in flight.
// throughput: one item per cycle while rsp is not stalled; a new hue may enter every clock.
// pipeline: 3 stages in the wheel (reciprocal multiply, remainder,
// ramps) and 9 in the normalizer (brightness product, then one
// quotient bit per stage).
// reset clears every stage valid bit and reloads brightness; req is ready
// in the first cycle after reset.
// when rsp is stalled, stages fill up behind the held output; req ready
// falls only once every stage holds an item, and nothing is dropped.
// ----------------------------------------------------------------------------
module hue_wheel_to_rgb_normalized (
   input  logic      clock,
   input  logic      reset,
   hwr_req_if.sink   req,
   hwr_rsp_if.source rsp,
   input  logic      csr_we,
   input  logic [7:0] csr_wdata
);
   import hwr_pkg::*;

   logic [7:0] brightness_ff;
   logic       mid_valid;
   logic       mid_ready;
   chan_type   mid_chan;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BrightnessReset;
      end else if (csr_we) begin
         brightness_ff <= csr_wdata;
      end
   end

   hwr_wheel u_wheel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_hue    (req.hue),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_chan  (mid_chan)
   );

   hwr_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .brightness (brightness_ff),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_chan    (mid_chan),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_red    (rsp.red),
      .out_green  (rsp.green),
      .out_blue   (rsp.blue)
   );

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) $past(reset) |-> !rsp.valid)
      else $error("rsp valid right after reset");

   a_share_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({2'b0, rsp.red} + {2'b0, rsp.green} + {2'b0, rsp.blue})
                    <= {2'b0, brightness_ff})
      else $error("channels exceed brightness");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("req stalled with empty output stage");
`endif

endmodule

// ===== test/hwr_checker.sv =====
// ----------------------------------------------------------------------------
// hwr_checker
// watches the hue and rgb channels, predicts each triple and compares it
// ----------------------------------------------------------------------------
// every accepted hue is turned into the rgb triple it should produce, using a
// shadow of the brightness register that follows csr writes. accepted results
// are matched in order against those triples, field by field. the failure
// count and the number of triples still awaited go back to the testbench top.
// ----------------------------------------------------------------------------
module hwr_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   hwr_req_if         req,
   hwr_rsp_if         rsp,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   rgb_type     rgb_q[$];
   logic [15:0] hue_q[$];
   logic [7:0]  level;
   rgb_type     want;
   logic [15:0] want_hue;
   int          errs = 0;

   function automatic int unsigned ramp_255(input int unsigned offset);
      return (offset * 255) / 60;
   endfunction

   function automatic rgb_type wheel_rgb(input logic [15:0] hue, input logic [7:0] bright);
      int unsigned h, r, g, b, total;
      rgb_type     c;
      h = hue % 360;
      if (h >= 300 || h <= 60) r = 255;
      else if (h < 120) r = ramp_255(120 - h);
      else if (h <= 240) r = 0;
      else r = ramp_255(h - 240);
      if (h == 0 || h >= 240) g = 0;
      else if (h < 60) g = ramp_255(h);
      else if (h <= 180) g = 255;
      else g = ramp_255(240 - h);
      if (h <= 120) b = 0;
      else if (h < 180) b = ramp_255(h - 120);
      else if (h <= 300) b = 255;
      else b = ramp_255(360 - h);
      total = r + g + b;
      c.red   = 8'((r * bright) / total);
      c.green = 8'((g * bright) / total);
      c.blue  = 8'((b * bright) / total);
      return c;
   endfunction

   task automatic check_field(input string name, input logic [15:0] hue,
                              input logic [7:0] exp_val, input logic [7:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s mismatch for hue %0d: expected %0d, got %0d", name, hue, exp_val, got_val);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         level = hwr_pkg::BrightnessReset;
         rgb_q.delete();
         hue_q.delete();
      end else begin
         if (csr_we) level = csr_wdata;
         if (req.valid && req.ready) begin
            rgb_q.push_back(wheel_rgb(req.hue, level));
            hue_q.push_back(req.hue);
         end
         if (rsp.valid && rsp.ready) begin
            if (rgb_q.size() == 0) begin
               $error("unexpected item: red %0d, green %0d, blue %0d",
                      rsp.red, rsp.green, rsp.blue);
               errs++;
            end else begin
               want     = rgb_q.pop_front();
               want_hue = hue_q.pop_front();
               check_field("red", want_hue, want.red, rsp.red);
               check_field("green", want_hue, want.green, rsp.green);
               check_field("blue", want_hue, want.blue, rsp.blue);
            end
         end
      end
      pending    <= rgb_q.size();
      fail_count <= errs;
   end

endmodule

// ===== test/hue_wheel_to_rgb_normalized_tb.sv =====
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb_normalized_tb
// stimulus and verdict for the hue wheel to normalized rgb block
// ----------------------------------------------------------------------------
// sends the segment boundaries and wraparound hues first, then random hues
// under several brightness settings, 0 and 255 among them. both channels
// idle at random per item, in stretches that change mode. the checker
// beside the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module hue_wheel_to_rgb_normalized_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 20;
   localparam int PhaseItems  = 140;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [7:0] csr_wdata;
   logic       send_gaps;
   logic       recv_stalls;
   int         fail_count;
   int         pending;
   int         cycles = 0;
   int         hues_sent = 0;
   int         settings_used = 1;

   hwr_req_if req_if ();
   hwr_rsp_if rsp_if ();

   hue_wheel_to_rgb_normalized u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   hwr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req        (req_if),
      .rsp        (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_hue(input logic [15:0] value);
      int gap;
      gap = send_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.hue   <= value;
      do @(posedge clock); while (!req_if.ready);
      hues_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_brightness(input logic [7:0] value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_hue();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return 16'($urandom_range(0, 359));
      if (k < 7) return 16'($urandom);
      // near a segment boundary, on some turn of the wheel
      if (k == 7)
         return 16'(360 * $urandom_range(0, 181) + 60 * $urandom_range(0, 6)
                    + $urandom_range(0, 2) - 1);
      return 16'(360 * $urandom_range(0, 180) + $urandom_range(0, 359));
   endfunction

   initial begin
      rsp_if.ready <= 1'b0;
      repeat (6) @(posedge clock);
      forever begin
         int stall;
         stall = recv_stalls ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      logic [15:0] edge_hues[$];
      logic [7:0]  levels[$];
      int          mode;
      edge_hues = '{16'd0, 16'd1, 16'd30, 16'd59, 16'd60, 16'd61, 16'd119, 16'd120,
                    16'd121, 16'd179, 16'd180, 16'd181, 16'd239, 16'd240, 16'd241,
                    16'd299, 16'd300, 16'd301, 16'd359, 16'd360, 16'd361, 16'd420,
                    16'hAAAA, 16'h5555, 16'hFFFF};
      levels = '{8'd255, 8'd0, 8'd1, 8'd128};
      levels.push_back(8'($urandom));
      levels.push_back(8'($urandom));
      req_if.valid <= 1'b0;
      req_if.hue   <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      send_gaps    = 1'b1;
      recv_stalls  = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (edge_hues[i]) send_hue(edge_hues[i]);

      foreach (levels[p]) begin
         set_brightness(levels[p]);
         for (int i = 0; i < PhaseItems; i++) begin
            if (i % 35 == 0) begin
               mode        = (p == 0 && i == 0) ? 0 : $urandom_range(0, 3);
               send_gaps   = mode[0];
               recv_stalls = mode[1];
            end
            if (i == PhaseItems / 2 && (p == 0 || $urandom_range(0, 1) == 1))
               wait_for_results();
            send_hue(pick_hue());
         end
      end

      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d hues: segment boundaries, wraparound and random turns",
               hues_sent);
      $display("under %0d brightness settings including 0, 1 and 255, with random idling",
               settings_used);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/hwr_pkg.sv
design/hwr_req_if.sv
design/hwr_rsp_if.sv
design/hwr_wheel.sv
design/hwr_norm.sv
design/hue_wheel_to_rgb_normalized.sv
test/hwr_checker.sv
test/hue_wheel_to_rgb_normalized_tb.sv
